### design/ffba_pkg.sv
package ffba_pkg;

  // Function codes of an input word
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_ADDED     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Width of the size and id fields on the ports
  localparam int PORT_SIZE_W = 16;
  localparam int PORT_ID_W   = 8;

  // Table access strobes from the controller
  typedef struct packed {
    logic rd;
    logic wr_size;
    logic wr_id;
  } tbl_ctl_t;

endpackage

### design/ffba_table.sv
module ffba_table #(
  parameter int DEPTH     = 16,
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                        clk,
  input  ffba_pkg::tbl_ctl_t          ctl,
  input  logic [IDX_W-1:0]            addr,
  input  logic [SIZE_BITS-1:0]        wr_size,
  input  logic [ffba_pkg::PORT_ID_W-1:0] wr_id,
  output logic [SIZE_BITS-1:0]        rd_size,
  output logic [ffba_pkg::PORT_ID_W-1:0] rd_id
);
  import ffba_pkg::*;

  logic [SIZE_BITS-1:0] size_mem [DEPTH];
  logic [PORT_ID_W-1:0] id_mem   [DEPTH];

  logic [SIZE_BITS-1:0] rd_size_r;
  logic [PORT_ID_W-1:0] rd_id_r;

  // Single port per cycle: write or registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_size) begin
      size_mem[addr] <= wr_size;
    end
    if (ctl.wr_id) begin
      id_mem[addr] <= wr_id;
    end
    if (ctl.rd) begin
      rd_size_r <= size_mem[addr];
      rd_id_r   <= id_mem[addr];
    end
  end

  assign rd_size = rd_size_r;
  assign rd_id   = rd_id_r;

endmodule

### design/ffba_ctrl.sv
module ffba_ctrl #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int IDX_W      = 4,
  parameter int CNT_W      = 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [SIZE_BITS-1:0]           in_req,
  input  logic [ffba_pkg::PORT_ID_W-1:0] in_new_block_id,
  output ffba_pkg::tbl_ctl_t             tbl_ctl,
  output logic [IDX_W-1:0]               tbl_addr,
  output logic [SIZE_BITS-1:0]           tbl_wr_size,
  output logic [ffba_pkg::PORT_ID_W-1:0] tbl_wr_id,
  input  logic [SIZE_BITS-1:0]           tbl_rd_size,
  input  logic [ffba_pkg::PORT_ID_W-1:0] tbl_rd_id,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [ffba_pkg::PORT_ID_W-1:0] out_granted_id,
  output logic [ffba_pkg::PORT_SIZE_W-1:0] out_granted_size
);
  import ffba_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_BLOCKS);

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [SIZE_BITS-1:0]   req_r, req_nxt;
  logic                   valid_r, valid_nxt;
  status_t                status_r, status_nxt;
  logic [PORT_ID_W-1:0]   gid_r, gid_nxt;
  logic [PORT_SIZE_W-1:0] gsize_r, gsize_nxt;
  logic [SIZE_BITS+PORT_SIZE_W-1:0] rd_size_ext;
  logic                   last_entry;

  assign rd_size_ext = {{PORT_SIZE_W{1'b0}}, tbl_rd_size};
  assign last_entry  = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    req_nxt     = req_r;
    valid_nxt   = 1'b0;
    status_nxt  = status_r;
    gid_nxt     = '0;
    gsize_nxt   = '0;
    tbl_ctl     = '0;
    tbl_addr    = idx_r;
    tbl_wr_size = in_req;
    tbl_wr_id   = in_new_block_id;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FUNC_ADD) begin
            valid_nxt = 1'b1;
            if (count_r == FULL_CNT) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt      = ST_ADDED;
              tbl_ctl.wr_size = 1'b1;
              tbl_ctl.wr_id   = 1'b1;
              tbl_addr        = count_r[IDX_W-1:0];
              count_nxt       = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            valid_nxt  = 1'b1;
            status_nxt = ST_NO_FIT;
          end else begin
            // issue read of the head entry
            tbl_ctl.rd = 1'b1;
            tbl_addr   = '0;
            idx_nxt    = '0;
            req_nxt    = in_req;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tbl_rd_size >= req_r) begin
          // grant and clear the stored size
          tbl_ctl.wr_size = 1'b1;
          tbl_wr_size     = '0;
          valid_nxt       = 1'b1;
          status_nxt      = ST_ALLOCATED;
          gid_nxt         = tbl_rd_id;
          gsize_nxt       = rd_size_ext[PORT_SIZE_W-1:0];
          state_nxt       = S_IDLE;
        end else if (last_entry) begin
          valid_nxt  = 1'b1;
          status_nxt = ST_NO_FIT;
          state_nxt  = S_IDLE;
        end else begin
          tbl_ctl.rd = 1'b1;
          tbl_addr   = idx_r + IDX_W'(1);
          idx_nxt    = idx_r + IDX_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      valid_r  <= 1'b0;
      status_r <= ST_ALLOCATED;
      gid_r    <= '0;
      gsize_r  <= '0;
      idx_r    <= '0;
      req_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      valid_r  <= valid_nxt;
      status_r <= status_nxt;
      gid_r    <= gid_nxt;
      gsize_r  <= gsize_nxt;
      idx_r    <= idx_nxt;
      req_r    <= req_nxt;
    end
  end

  assign busy             = (state_r == S_SCAN);
  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_granted_id   = gid_r;
  assign out_granted_size = gsize_r;

endmodule

### design/first_fit_block_allocator.sv
// First-fit block allocator.
//
// Input channel: a word is taken at a rising edge where start is high and
// busy is low. in_func selects add (append in_new_block_id / in_request_size
// at the tail of the table) or allocate (grant the first entry, from the head,
// whose stored size is at least in_request_size, then zero that size).
//
// Result channel: every input word yields exactly one result word, shown on
// out_status / out_granted_id / out_granted_size for one cycle with out_valid
// high. The receiver cannot stall; results are never held.
//
// Timing: an add, or an allocate on an empty table, returns its result in
// the cycle after acceptance and busy stays low, so a new word may follow
// at once. An allocate scans the table through its single memory port from
// the head, one entry per cycle, each entry passing through the table's
// registered read; it ends at the first fitting entry or the last entry.
// busy is high for the scan, so no new word is taken until it ends.
//
// Reset (rst_n low, synchronous) empties the table; stored entries are not
// cleared since only entries below the fill count are ever read.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_request_size,
  input  logic [7:0]  in_new_block_id,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [7:0]  out_granted_id,
  output logic [15:0] out_granted_size
);
  import ffba_pkg::*;

  // Index wide enough for the table, count wide enough to hold MAX_BLOCKS
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  tbl_ctl_t                tbl_ctl;
  logic [IDX_W-1:0]        tbl_addr;
  logic [SIZE_BITS-1:0]    tbl_wr_size;
  logic [PORT_ID_W-1:0]    tbl_wr_id;
  logic [SIZE_BITS-1:0]    tbl_rd_size;
  logic [PORT_ID_W-1:0]    tbl_rd_id;
  logic [SIZE_BITS+PORT_SIZE_W-1:0] req_ext;
  logic [SIZE_BITS-1:0]    req_masked;

  // Keep only the low SIZE_BITS bits of the request
  assign req_ext    = {{SIZE_BITS{1'b0}}, in_request_size};
  assign req_masked = req_ext[SIZE_BITS-1:0];

  ffba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_req           (req_masked),
    .in_new_block_id  (in_new_block_id),
    .tbl_ctl          (tbl_ctl),
    .tbl_addr         (tbl_addr),
    .tbl_wr_size      (tbl_wr_size),
    .tbl_wr_id        (tbl_wr_id),
    .tbl_rd_size      (tbl_rd_size),
    .tbl_rd_id        (tbl_rd_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_granted_id   (out_granted_id),
    .out_granted_size (out_granted_size)
  );

  ffba_table #(
    .DEPTH     (MAX_BLOCKS),
    .SIZE_BITS (SIZE_BITS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk     (clk),
    .ctl     (tbl_ctl),
    .addr    (tbl_addr),
    .wr_size (tbl_wr_size),
    .wr_id   (tbl_wr_id),
    .rd_size (tbl_rd_size),
    .rd_id   (tbl_rd_id)
  );

endmodule

### design/ffba_checker.sv
module ffba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_func,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [7:0]  out_granted_id,
  input logic [15:0] out_granted_size
);
  import ffba_pkg::*;

  // A result closes the scan, so busy is already low
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Add answers in the next cycle
  a_add_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_ADD) |=> out_valid)
    else $error("add result missing");

  // Allocate either answers at once or starts a scan
  a_alloc_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_ALLOC) |=> (out_valid || busy))
    else $error("allocate dropped");

  // Only a grant carries an id and size
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ALLOCATED) |->
      (out_granted_id == '0 && out_granted_size == '0))
    else $error("nonzero payload without grant");

  // Every result traces back to an accepted word or a running scan
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a request");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
